/* rtl/lcat_pkg.sv */
// Shared types and constants of the lowest common ancestor table unit.
// Holds the word formats, function and status codes and the sequencer states.
// No dependencies.
package lcat_pkg;

	localparam int NODE_W = 10;
	localparam int DEPTH_W = 10;
	localparam int DIST_W = 11;
	localparam int FUNC_W = 3;
	localparam int STATUS_W = 2;
	localparam int JUMP_W = 10;

	localparam int DEF_MAX_NODES = 1024;
	localparam int DEF_LOG_LEVELS = 10;

	localparam logic [DEPTH_W-1:0] DEPTH_LIMIT = 10'd1023;

	localparam logic [FUNC_W-1:0] FN_ADD = 3'd0;
	localparam logic [FUNC_W-1:0] FN_LCA = 3'd1;
	localparam logic [FUNC_W-1:0] FN_KTH = 3'd2;
	localparam logic [FUNC_W-1:0] FN_DIST = 3'd3;
	localparam logic [FUNC_W-1:0] FN_PATH = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
	localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd1;
	localparam logic [STATUS_W-1:0] ST_TREES = 2'd2;
	localparam logic [STATUS_W-1:0] ST_BADINS = 2'd3;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [NODE_W-1:0] node_a;
		logic [NODE_W-1:0] node_b;
		logic [NODE_W-1:0] node_c;
		logic [JUMP_W-1:0] jump_count;
		logic is_root;
	} item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [NODE_W-1:0] result_node;
		logic [DIST_W-1:0] distance;
		logic on_path;
	} result_t;

	typedef enum logic [4:0] {
		S_CLEAR,
		S_IDLE,
		S_RD_A,
		S_RD_B,
		S_RD_C,
		S_RD_D,
		S_DECIDE,
		S_FILL_ROOT,
		S_ADD_ISS,
		S_ADD_WR,
		S_CL_ISS,
		S_CL_WAIT,
		S_CM_EQ,
		S_CM_ISS,
		S_CM_CMP,
		S_CM_FIN_ISS,
		S_CM_FIN,
		S_CM_RET,
		S_DIST,
		S_DONE
	} state_t;

	// Position of the highest set bit of a jump count; zero for a zero count.
	function automatic logic [3:0] msb_pos(input logic [JUMP_W-1:0] k);
		logic [3:0] pos;
		pos = '0;
		for (int j = 0; j < JUMP_W; j++) begin
			if (k[j]) begin
				pos = 4'(j);
			end
		end
		return pos;
	endfunction

endpackage

/* rtl/lowest_common_ancestor_table_unit.sv */
// Top level of the lowest common ancestor table unit: sequencer, node store
// and ancestor table memories. Depends on lcat_pkg.
//
// This unit keeps a binary-lifting ancestor table over a forest and answers
// lowest common ancestor, k-th ancestor, distance and on-path queries. Each
// accepted word produces exactly one result word. Work is done one word at a
// time by a sequencer around two memories with registered reads: a node store
// (present flag, depth, root) and an ancestor table with one row per node.
// After reset the unit clears every node store entry and holds item_stall
// high meanwhile. Every word first reads the node store for its three nodes
// and then decides. An add then writes one table entry per level for a root,
// and one table read and write per level otherwise. A k-th ancestor query
// climbs by the largest power of two that fits the remaining jump, one table
// read per step. A common ancestor search climbs the deeper node to equal
// depth and then compares both nodes level by level, read through the two
// table read ports at once; a distance query then reads the depth of the
// common ancestor, and an on-path query runs three such searches when node_c
// shares the root of node_a. A finished result sits in an output register,
// so the next word is taken while the previous result still waits downstream.
module lowest_common_ancestor_table_unit #(
	parameter int MAX_NODES = lcat_pkg::DEF_MAX_NODES,
	parameter int LOG_LEVELS = lcat_pkg::DEF_LOG_LEVELS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_stall,
	input  lcat_pkg::item_t item,
	output logic result_valid,
	input  logic result_stall,
	output lcat_pkg::result_t result
);
	import lcat_pkg::*;

	localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int LW = (LOG_LEVELS > 0) ? $clog2(LOG_LEVELS + 1) : 1;
	localparam int IW = 1 + DEPTH_W + AW;
	localparam int ANC_DEPTH = MAX_NODES * (2 ** LW);
	localparam logic [LW-1:0] TOP_LVL = LW'(LOG_LEVELS);

	// Node store word: {present, depth, root}. Ancestor table row per node.
	logic [IW-1:0] info_mem [MAX_NODES];
	logic [AW-1:0] anc_mem [ANC_DEPTH];

	state_t state_q, state_d;

	logic info_we;
	logic [AW-1:0] info_wa, info_ra;
	logic [IW-1:0] info_wd, info_rd;
	logic anc_we;
	logic [AW+LW-1:0] anc_wa, anc_ra0, anc_ra1;
	logic [AW-1:0] anc_wd, anc_rd0, anc_rd1;

	logic [AW-1:0] clr_q;
	logic [FUNC_W-1:0] op_q;
	logic [NODE_W-1:0] a_q, b_q, c_q;
	logic [JUMP_W-1:0] k_q;
	logic is_root_q;
	logic pa_q, pb_q, pc_q;
	logic [DEPTH_W-1:0] da_q, db_q, dc_q;
	logic [AW-1:0] ra_q, rb_q, rc_q;
	logic [AW-1:0] u_q, v_q, cm_res_q, uv_q, us_q;
	logic [LW-1:0] lvl_q;
	logic [1:0] pass_q;
	logic [STATUS_W-1:0] st_q;
	logic [NODE_W-1:0] rn_q;
	logic [DIST_W-1:0] dist_q;
	logic onp_q;
	logic out_valid_q;
	result_t out_q;

	logic a_rng, b_rng, c_rng;
	logic add_bad, query_absent;
	logic [1:0] lp;
	logic [AW-1:0] lx, ly, cu, cv, climb_u;
	logic [DEPTH_W-1:0] ldx, ldy, cd;
	logic [JUMP_W-1:0] ck, climb_k, k_next;
	logic [LW-1:0] step_lvl;
	logic differ, lvl_dec, out_load;

	assign a_rng = 32'(a_q) < MAX_NODES;
	assign b_rng = 32'(b_q) < MAX_NODES;
	assign c_rng = 32'(c_q) < MAX_NODES;

	// Memories.
	always_ff @(posedge clk) begin
		if (info_we) begin
			info_mem[info_wa] <= info_wd;
		end
		info_rd <= info_mem[info_ra];
	end

	always_ff @(posedge clk) begin
		if (anc_we) begin
			anc_mem[anc_wa] <= anc_wd;
		end
		anc_rd0 <= anc_mem[anc_ra0];
		anc_rd1 <= anc_mem[anc_ra1];
	end

	// Setup of a climb: either a k-th ancestor jump from node_a, or the depth
	// equalizing climb at the start of a common ancestor search. The pass
	// picks the pair: a and b, then a and c, then b and c.
	always_comb begin
		lp = (state_q == S_DECIDE) ? 2'd0 : 2'(pass_q + 2'd1);
		case (lp)
			2'd0: begin
				lx = AW'(a_q); ly = AW'(b_q); ldx = da_q; ldy = db_q;
			end
			2'd1: begin
				lx = AW'(a_q); ly = AW'(c_q); ldx = da_q; ldy = dc_q;
			end
			default: begin
				lx = AW'(b_q); ly = AW'(c_q); ldx = db_q; ldy = dc_q;
			end
		endcase
		if (op_q == FN_KTH) begin
			cu = AW'(a_q); cv = ly; ck = k_q; cd = da_q;
		end else if (ldx < ldy) begin
			cu = ly; cv = lx; ck = ldy - ldx; cd = ldy;
		end else begin
			cu = lx; cv = ly; ck = ldx - ldy; cd = ldx;
		end
		// A jump at least as long as the depth saturates at the root.
		climb_u = (ck >= cd) ? ra_q : cu;
		climb_k = (ck >= cd) ? '0 : ck;
	end

	// Largest power of two that fits the remaining jump, capped at the top level.
	always_comb begin
		if (32'(k_q) >= (32'd1 << LOG_LEVELS)) begin
			step_lvl = TOP_LVL;
		end else begin
			step_lvl = LW'(msb_pos(k_q));
		end
		k_next = JUMP_W'(32'(k_q) - (32'd1 << step_lvl));
	end

	assign add_bad = !a_rng || pa_q || (!is_root_q && (!pb_q || db_q >= DEPTH_LIMIT));
	assign query_absent = !pa_q || !pb_q || (op_q == FN_PATH && !pc_q);
	assign differ = anc_rd0 != anc_rd1;
	assign lvl_dec = (lvl_q == TOP_LVL) ? !differ : (lvl_q != '0);
	assign out_load = (state_q == S_DONE) && (!out_valid_q || !result_stall);

	// Next state and memory controls.
	always_comb begin
		state_d = state_q;
		info_ra = AW'(a_q);
		info_we = 1'b0;
		info_wa = AW'(a_q);
		info_wd = '0;
		anc_ra0 = {u_q, lvl_q};
		anc_ra1 = {v_q, lvl_q};
		anc_we = 1'b0;
		anc_wa = {AW'(a_q), lvl_q};
		anc_wd = AW'(a_q);
		case (state_q)
			S_CLEAR: begin
				info_we = 1'b1;
				info_wa = clr_q;
				if (clr_q == AW'(MAX_NODES - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (item_valid) begin
					state_d = S_RD_A;
				end
			end
			S_RD_A: begin
				info_ra = AW'(a_q);
				state_d = S_RD_B;
			end
			S_RD_B: begin
				info_ra = AW'(b_q);
				state_d = S_RD_C;
			end
			S_RD_C: begin
				info_ra = AW'(c_q);
				state_d = S_RD_D;
			end
			S_RD_D: state_d = S_DECIDE;
			S_DECIDE: begin
				case (op_q)
					FN_ADD: begin
						if (add_bad) begin
							state_d = S_DONE;
						end else begin
							info_we = 1'b1;
							info_wa = AW'(a_q);
							info_wd = is_root_q ? {1'b1, DEPTH_W'(0), AW'(a_q)}
								: {1'b1, DEPTH_W'(db_q + 1'b1), rb_q};
							anc_we = 1'b1;
							anc_wa = {AW'(a_q), LW'(0)};
							anc_wd = is_root_q ? AW'(a_q) : AW'(b_q);
							state_d = is_root_q ? S_FILL_ROOT : S_ADD_ISS;
						end
					end
					FN_KTH: state_d = pa_q ? S_CL_ISS : S_DONE;
					FN_LCA, FN_DIST, FN_PATH: begin
						if (query_absent || ra_q != rb_q) begin
							state_d = S_DONE;
						end else begin
							state_d = S_CL_ISS;
						end
					end
					default: state_d = S_DONE;
				endcase
			end
			S_FILL_ROOT: begin
				anc_we = 1'b1;
				if (lvl_q == TOP_LVL) begin
					state_d = S_DONE;
				end
			end
			S_ADD_ISS: begin
				anc_ra0 = {u_q, LW'(lvl_q - LW'(1))};
				state_d = S_ADD_WR;
			end
			S_ADD_WR: begin
				anc_we = 1'b1;
				anc_wd = anc_rd0;
				state_d = (lvl_q == TOP_LVL) ? S_DONE : S_ADD_ISS;
			end
			S_CL_ISS: begin
				anc_ra0 = {u_q, step_lvl};
				if (k_q == '0) begin
					state_d = (op_q == FN_KTH) ? S_DONE : S_CM_EQ;
				end else begin
					state_d = S_CL_WAIT;
				end
			end
			S_CL_WAIT: state_d = S_CL_ISS;
			S_CM_EQ: state_d = (u_q == v_q) ? S_CM_RET : S_CM_ISS;
			S_CM_ISS: state_d = S_CM_CMP;
			S_CM_CMP: begin
				if (lvl_q != TOP_LVL && lvl_q == '0) begin
					state_d = S_CM_FIN_ISS;
				end else begin
					state_d = S_CM_ISS;
				end
			end
			S_CM_FIN_ISS: begin
				anc_ra0 = {u_q, LW'(0)};
				state_d = S_CM_FIN;
			end
			S_CM_FIN: state_d = S_CM_RET;
			S_CM_RET: begin
				info_ra = cm_res_q;
				case (pass_q)
					2'd0: begin
						if (op_q == FN_DIST) begin
							state_d = S_DIST;
						end else if (op_q == FN_PATH && rc_q == ra_q) begin
							state_d = S_CL_ISS;
						end else begin
							state_d = S_DONE;
						end
					end
					2'd1: state_d = S_CL_ISS;
					default: state_d = S_DONE;
				endcase
			end
			S_DIST: state_d = S_DONE;
			S_DONE: begin
				if (!out_valid_q || !result_stall) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_q <= AW'(clr_q + 1'b1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= '{status: st_q, result_node: rn_q, distance: dist_q, on_path: onp_q};
		end
		case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					op_q <= item.func;
					a_q <= item.node_a;
					b_q <= item.node_b;
					c_q <= item.node_c;
					k_q <= item.jump_count;
					is_root_q <= item.is_root;
					st_q <= ST_OK;
					rn_q <= '0;
					dist_q <= '0;
					onp_q <= 1'b0;
				end
			end
			S_RD_B: begin
				pa_q <= a_rng && info_rd[IW-1];
				da_q <= info_rd[AW +: DEPTH_W];
				ra_q <= info_rd[AW-1:0];
			end
			S_RD_C: begin
				pb_q <= b_rng && info_rd[IW-1];
				db_q <= info_rd[AW +: DEPTH_W];
				rb_q <= info_rd[AW-1:0];
			end
			S_RD_D: begin
				pc_q <= c_rng && info_rd[IW-1];
				dc_q <= info_rd[AW +: DEPTH_W];
				rc_q <= info_rd[AW-1:0];
			end
			S_DECIDE: begin
				case (op_q)
					FN_ADD: begin
						if (add_bad) begin
							st_q <= ST_BADINS;
						end else begin
							lvl_q <= LW'(1);
							u_q <= AW'(b_q);
						end
					end
					FN_KTH: begin
						if (!pa_q) begin
							st_q <= ST_ABSENT;
						end else begin
							u_q <= climb_u;
							k_q <= climb_k;
						end
					end
					FN_LCA, FN_DIST, FN_PATH: begin
						if (query_absent) begin
							st_q <= ST_ABSENT;
						end else if (ra_q != rb_q) begin
							st_q <= ST_TREES;
						end else begin
							u_q <= climb_u;
							v_q <= cv;
							k_q <= climb_k;
							pass_q <= 2'd0;
						end
					end
					default: ;
				endcase
			end
			S_FILL_ROOT: lvl_q <= LW'(lvl_q + 1'b1);
			S_ADD_WR: begin
				u_q <= anc_rd0;
				lvl_q <= LW'(lvl_q + 1'b1);
			end
			S_CL_ISS: begin
				if (k_q == '0) begin
					// Only the k-th ancestor query reports the climbed node.
					if (op_q == FN_KTH) begin
						rn_q <= NODE_W'(u_q);
					end
				end else begin
					k_q <= k_next;
				end
			end
			S_CL_WAIT: u_q <= anc_rd0;
			S_CM_EQ: begin
				cm_res_q <= u_q;
				lvl_q <= TOP_LVL;
			end
			S_CM_CMP: begin
				if (differ) begin
					u_q <= anc_rd0;
					v_q <= anc_rd1;
				end
				if (lvl_dec) begin
					lvl_q <= LW'(lvl_q - LW'(1));
				end
			end
			S_CM_FIN: cm_res_q <= anc_rd0;
			S_CM_RET: begin
				case (pass_q)
					2'd0: begin
						rn_q <= (op_q == FN_LCA) ? NODE_W'(cm_res_q) : '0;
						uv_q <= cm_res_q;
						u_q <= climb_u;
						v_q <= cv;
						k_q <= climb_k;
						pass_q <= 2'd1;
					end
					2'd1: begin
						us_q <= cm_res_q;
						u_q <= climb_u;
						v_q <= cv;
						k_q <= climb_k;
						pass_q <= 2'd2;
					end
					default: begin
						onp_q <= (uv_q == AW'(c_q))
							|| (us_q == uv_q && cm_res_q == AW'(c_q))
							|| (cm_res_q == uv_q && us_q == AW'(c_q));
					end
				endcase
			end
			S_DIST: begin
				dist_q <= DIST_W'(12'({2'b00, da_q}) + 12'({2'b00, db_q})
					- 12'({1'b0, info_rd[AW +: DEPTH_W], 1'b0}));
			end
			default: ;
		endcase
	end

	assign item_stall = state_q != S_IDLE;
	assign result_valid = out_valid_q;
	assign result = out_q;

`ifndef NO_ASSERTIONS
	// The lifting level never runs past the top row of the table.
	a_lvl_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CM_ISS || state_q == S_FILL_ROOT || state_q == S_ADD_ISS)
			|-> 32'(lvl_q) <= LOG_LEVELS)
		else $error("ancestor level beyond top row");

	// Two distinct nodes at equal depth stay distinct while their ancestors differ.
	a_cm_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CM_ISS |-> u_q != v_q)
		else $error("common ancestor search compares a node with itself");

	// A result word is only presented after a word has been worked through.
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_DONE)
		else $error("result word appeared without a finished item");
`endif

endmodule
